// ===== rtl/e2q_pkg.sv =====
`default_nettype none
package e2q_pkg;

  // working width of all q30 values (sign plus headroom)
  localparam int QW = 34;

  typedef logic signed [QW-1:0] q_t;

  localparam q_t Q30_ONE = q_t'(64'sd1073741824);

  // odd taylor coefficients of sin(pi/2 * t), q30
  localparam q_t POLY_C1 = q_t'(64'sd1686629713);
  localparam q_t POLY_C3 = q_t'(-64'sd693598668);
  localparam q_t POLY_C5 = q_t'(64'sd85569306);
  localparam q_t POLY_C7 = q_t'(-64'sd5026995);
  localparam q_t POLY_C9 = q_t'(64'sd172272);

  // pipeline depth of one rounded q30 multiply
  localparam int MUL_LAT = 2;
  // pipeline depth of the sine polynomial
  localparam int SIN_LAT = 6 * MUL_LAT;

endpackage
`default_nettype wire

// ===== rtl/e2q_mul.sv =====
`default_nettype none
// q30 x q30 multiply, rounded half away from zero, plus an addend
// two stages: product, then round / sign / add
module e2q_mul (
  input  wire logic           clk,
  input  wire logic           en,
  input  e2q_pkg::q_t         a,
  input  e2q_pkg::q_t         b,
  input  e2q_pkg::q_t         addend,
  output e2q_pkg::q_t         p
);

  logic [31:0]       mag_a;
  logic [31:0]       mag_b;
  logic [63:0]       prod_r;
  logic              neg_r;
  e2q_pkg::q_t       add_r;
  logic [63:0]       rnd;
  e2q_pkg::q_t       mag_q;
  e2q_pkg::q_t       p_r;

  // operand magnitudes stay below 2^32
  always_comb begin
    mag_a = a[e2q_pkg::QW-1] ? 32'(-a) : 32'(a);
    mag_b = b[e2q_pkg::QW-1] ? 32'(-b) : 32'(b);
  end

  // stage one: unsigned product
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= mag_a * mag_b;
      neg_r  <= a[e2q_pkg::QW-1] ^ b[e2q_pkg::QW-1];
      add_r  <= addend;
    end
  end

  // stage two: round back to q30, restore sign, add
  always_comb begin
    rnd   = prod_r + 64'(1 << 29);
    mag_q = e2q_pkg::q_t'(rnd[63:30]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (neg_r ? -mag_q : mag_q) + add_r;
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ===== rtl/e2q_sin.sv =====
`default_nettype none
// sin(pi/2 * t) by horner's rule over six pipelined multiplies
module e2q_sin (
  input  wire logic    clk,
  input  wire logic    en,
  input  e2q_pkg::q_t  t,
  output e2q_pkg::q_t  s
);

  e2q_pkg::q_t t2;
  e2q_pkg::q_t p1;
  e2q_pkg::q_t p2;
  e2q_pkg::q_t p3;
  e2q_pkg::q_t p4;
  e2q_pkg::q_t t_d_r  [10];
  e2q_pkg::q_t t2_d_r [6];

  // delay lines for t and t squared
  always_ff @(posedge clk) begin
    if (en) begin
      t_d_r[0]  <= t;
      t2_d_r[0] <= t2;
      for (int i = 1; i < 10; i++) t_d_r[i]  <= t_d_r[i-1];
      for (int i = 1; i < 6; i++)  t2_d_r[i] <= t2_d_r[i-1];
    end
  end

  e2q_mul u_sq (.clk, .en, .a(t), .b(t), .addend('0), .p(t2));
  e2q_mul u_h1 (.clk, .en, .a(e2q_pkg::POLY_C9), .b(t2),
                .addend(e2q_pkg::POLY_C7), .p(p1));
  e2q_mul u_h2 (.clk, .en, .a(p1), .b(t2_d_r[1]), .addend(e2q_pkg::POLY_C5), .p(p2));
  e2q_mul u_h3 (.clk, .en, .a(p2), .b(t2_d_r[3]), .addend(e2q_pkg::POLY_C3), .p(p3));
  e2q_mul u_h4 (.clk, .en, .a(p3), .b(t2_d_r[5]), .addend(e2q_pkg::POLY_C1), .p(p4));
  e2q_mul u_fin (.clk, .en, .a(p4), .b(t_d_r[9]), .addend('0), .p(s));

endmodule
`default_nettype wire

// ===== rtl/euler_to_quaternion.sv =====
`default_nettype none
// channel | direction | beat contents
// in_     | slave     | tdata: roll_angle, pitch_angle, yaw_angle (ANGLE_BITS each)
// out_    | master    | tdata: quat_w, quat_x, quat_y, quat_z (OUT_BITS each)
//
// one beat per cycle in while the pipeline advances, one result beat out for each
// the pipeline holds one angle stage, six serial multiplies of the sine
// polynomial, two more products and the saturating output stage
// the whole pipeline advances whenever the output register is empty or taken
// reset clears only the valid bits
module euler_to_quaternion #(
  parameter int ANGLE_BITS = 16,
  parameter int OUT_BITS   = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // roll_angle, pitch_angle, yaw_angle, zero fill
  input  wire logic [((3*ANGLE_BITS+7)/8)*8-1:0]     in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // quat_w, quat_x, quat_y, quat_z, zero fill
  output logic [((4*OUT_BITS+7)/8)*8-1:0]            out_tdata
);

  localparam int QW    = e2q_pkg::QW;
  localparam int OUT_W = ((4*OUT_BITS+7)/8)*8;
  localparam int LAT   = 1 + e2q_pkg::SIN_LAT + 2*e2q_pkg::MUL_LAT + 1;
  localparam logic signed [QW+1:0] OHI =
    $signed({{(QW+3-OUT_BITS){1'b0}}, {(OUT_BITS-1){1'b1}}});
  localparam logic signed [QW+1:0] OLO = -OHI - 1;

  logic                  en;
  logic [LAT-1:0]        vld_r;
  e2q_pkg::q_t           sarg_r [3];
  e2q_pkg::q_t           carg_r [3];
  e2q_pkg::q_t           sv [3];
  e2q_pkg::q_t           cv [3];
  e2q_pkg::q_t           c3_d_r [2];
  e2q_pkg::q_t           s3_d_r [2];
  e2q_pkg::q_t           c1c2, s1s2, s1c2, c1s2;
  e2q_pkg::q_t           tp [8];
  logic signed [QW:0]    sum [4];
  logic signed [QW+1:0]  conv [4];
  logic [OUT_BITS-1:0]   q_r [4];

  // global advance: output slot free or being taken
  assign en        = ~vld_r[LAT-1] | out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // angle stage: binary angle to half-angle phase, sine and cosine arguments
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic [31:0]        ph;
        logic signed [31:0] h;
        e2q_pkg::q_t        hq;
        ph = 32'(in_tdata[k*ANGLE_BITS +: ANGLE_BITS]) << (32 - ANGLE_BITS);
        h  = $signed(ph) >>> 1;
        hq = e2q_pkg::q_t'(h);
        sarg_r[k] <= hq;
        carg_r[k] <= e2q_pkg::Q30_ONE - (hq[QW-1] ? -hq : hq);
      end
    end
  end

  // sine and cosine units, one pair per axis
  for (genvar k = 0; k < 3; k++) begin : g_axis
    e2q_sin u_sin (.clk, .en, .t(sarg_r[k]), .s(sv[k]));
    e2q_sin u_cos (.clk, .en, .t(carg_r[k]), .s(cv[k]));
  end

  // hold yaw terms while the roll-pitch pairs form
  always_ff @(posedge clk) begin
    if (en) begin
      c3_d_r[0] <= cv[2];
      c3_d_r[1] <= c3_d_r[0];
      s3_d_r[0] <= sv[2];
      s3_d_r[1] <= s3_d_r[0];
    end
  end

  // roll-pitch pair products
  e2q_mul u_cc (.clk, .en, .a(cv[0]), .b(cv[1]), .addend('0), .p(c1c2));
  e2q_mul u_ss (.clk, .en, .a(sv[0]), .b(sv[1]), .addend('0), .p(s1s2));
  e2q_mul u_sc (.clk, .en, .a(sv[0]), .b(cv[1]), .addend('0), .p(s1c2));
  e2q_mul u_cs (.clk, .en, .a(cv[0]), .b(sv[1]), .addend('0), .p(c1s2));

  // triple products
  e2q_mul u_t0 (.clk, .en, .a(c1c2), .b(c3_d_r[1]), .addend('0), .p(tp[0]));
  e2q_mul u_t1 (.clk, .en, .a(s1s2), .b(s3_d_r[1]), .addend('0), .p(tp[1]));
  e2q_mul u_t2 (.clk, .en, .a(s1c2), .b(c3_d_r[1]), .addend('0), .p(tp[2]));
  e2q_mul u_t3 (.clk, .en, .a(c1s2), .b(s3_d_r[1]), .addend('0), .p(tp[3]));
  e2q_mul u_t4 (.clk, .en, .a(c1s2), .b(c3_d_r[1]), .addend('0), .p(tp[4]));
  e2q_mul u_t5 (.clk, .en, .a(s1c2), .b(s3_d_r[1]), .addend('0), .p(tp[5]));
  e2q_mul u_t6 (.clk, .en, .a(c1c2), .b(s3_d_r[1]), .addend('0), .p(tp[6]));
  e2q_mul u_t7 (.clk, .en, .a(s1s2), .b(c3_d_r[1]), .addend('0), .p(tp[7]));

  // component sums
  always_comb begin
    sum[0] = (QW+1)'(tp[0]) - (QW+1)'(tp[1]);
    sum[1] = (QW+1)'(tp[2]) + (QW+1)'(tp[3]);
    sum[2] = (QW+1)'(tp[4]) - (QW+1)'(tp[5]);
    sum[3] = (QW+1)'(tp[6]) + (QW+1)'(tp[7]);
  end

  // q30 to output format
  for (genvar j = 0; j < 4; j++) begin : g_conv
    if (OUT_BITS >= 32) begin : g_dbl
      assign conv[j] = (QW+2)'(sum[j]) <<< 1;
    end else if (OUT_BITS == 31) begin : g_same
      assign conv[j] = (QW+2)'(sum[j]);
    end else begin : g_rnd
      localparam int SH = 31 - OUT_BITS;
      logic [QW:0] mag;
      logic [QW:0] r;
      always_comb begin
        mag = sum[j][QW] ? (QW+1)'(-sum[j]) : (QW+1)'(sum[j]);
        r   = (mag + (QW+1)'(1 << (SH-1))) >> SH;
        conv[j] = sum[j][QW] ? -$signed({1'b0, r}) : $signed({1'b0, r});
      end
    end
  end

  // saturate into output register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        if (conv[j] > OHI)      q_r[j] <= OHI[OUT_BITS-1:0];
        else if (conv[j] < OLO) q_r[j] <= OLO[OUT_BITS-1:0];
        else                    q_r[j] <= conv[j][OUT_BITS-1:0];
      end
    end
  end

  assign out_tdata = OUT_W'({q_r[3], q_r[2], q_r[1], q_r[0]});

endmodule
`default_nettype wire
